// File: rtl/core/sorted_key_table_defines.svh
// Assertion macros for the sorted key table RTL.
// Expects signals clk and rst_n in the module that uses them.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SKT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SKT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sktab_pkg.sv
// Package for the sorted key table: field widths, codes and item types.
// No dependencies.
`timescale 1ns / 1ps

package sktab_pkg;

    localparam int SKT_CAPACITY = 64;
    localparam int KEY_W        = 14;
    localparam int PAYLOAD_W    = 32;
    localparam int DLEN_W       = 8;
    localparam int COUNT_W      = 7;

    localparam logic [KEY_W-1:0]  KEY_LIMIT  = KEY_W'(9999);
    localparam logic [DLEN_W-1:0] DESC_LIMIT = DLEN_W'(40);

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_LOOKUP = 2'd2
    } sktab_func_t;

    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_OK     = 2'd1,
        ST_DUP    = 2'd2
    } sktab_status_t;

    typedef struct packed {
        logic [1:0]           func;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [DLEN_W-1:0]    desc_length;
    } sktab_in_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [PAYLOAD_W-1:0] found_payload;
        logic [COUNT_W-1:0]   count;
        logic                 empty_res;
    } sktab_out_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } sktab_entry_t;

endpackage

// File: rtl/core/sorted_key_table.sv
// Sorted key table top level: sequencer, entry count, config register.
// Depends on sktab_pkg, sktab_mem, sktab_search, sorted_key_table_defines.svh.
//
//  channel   dir   handshake            payload
//  in        in    in_valid/in_ready    in_data  (func, key, payload, desc_length)
//  out       out   out_valid/out_ready  out_data (status, found_payload, count, empty_res)
//  cfg       in    cfg_valid/cfg_ready  cfg_data (sorted_mode)
//
// The scan reads the N stored entries, one read per cycle, and compares them; N is the entry
// count. A reject, duplicate, lookup or no-op then registers its result; a commit first moves
// the M entries behind its position, if any, then commits and registers its result.
// Longest case: remove of the first entry of a full table.
// in_ready is high only in idle; the next item may be accepted while a result waits,
// and it stalls in its last step until the output register is free.
// No clearing pass after reset; cfg is always ready.
`timescale 1ns / 1ps
`include "sorted_key_table_defines.svh"

module sorted_key_table #(
    parameter int CAPACITY = sktab_pkg::SKT_CAPACITY
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sktab_pkg::sktab_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sktab_pkg::sktab_out_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    import sktab_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_DECIDE = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_COMMIT = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic               sorted_mode_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    sktab_in_t          item_reg;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   src_reg, src_next;
    logic [IDX_W-1:0]   dst_reg, dst_next;
    logic [CNT_W-1:0]   moves_reg, moves_next;
    logic               pend_reg, pend_next;
    logic               up_reg, up_next;
    logic [1:0]         status_reg, status_next;
    logic [PAYLOAD_W-1:0] found_reg, found_next;
    logic               out_valid_reg, out_valid_next;
    sktab_out_t         out_reg, out_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    sktab_entry_t       mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    sktab_entry_t       mem_rdata;

    logic               scan_clear;
    logic               match_found;
    logic [IDX_W-1:0]   match_idx;
    logic [PAYLOAD_W-1:0] match_payload;
    logic               ge_found;
    logic [IDX_W-1:0]   ge_idx;
    logic [IDX_W-1:0]   ins_pos;
    logic               in_fire;
    logic               out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign scan_clear = in_fire;

    sktab_mem #(.DEPTH(CAPACITY)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sktab_search #(.DEPTH(CAPACITY)) u_search (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (scan_clear),
        .vld           (cmp_vld_reg),
        .idx           (cmp_idx_reg),
        .key           (item_reg.key),
        .entry         (mem_rdata),
        .match_found   (match_found),
        .match_idx     (match_idx),
        .match_payload (match_payload),
        .ge_found      (ge_found),
        .ge_idx        (ge_idx)
    );

    // sorted insert goes before the first key not below; append otherwise
    assign ins_pos = (sorted_mode_reg && ge_found) ? ge_idx : cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        pos_next       = pos_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        moves_next     = moves_reg;
        pend_next      = 1'b0;
        up_next        = up_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = dst_reg;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rd_ptr_next = '0;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (rd_ptr_reg < cnt_reg)
                begin
                    mem_re       = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                end
                else if (!cmp_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                status_next = ST_REJECT;
                found_next  = '0;
                state_next  = S_DONE;
                case (item_reg.func)
                    FN_INSERT:
                    begin
                        if (cnt_reg >= CNT_W'(CAPACITY) || item_reg.key > KEY_LIMIT
                            || item_reg.desc_length > DESC_LIMIT)
                        begin
                            status_next = ST_REJECT;
                        end
                        else if (match_found)
                        begin
                            status_next = ST_DUP;
                        end
                        else
                        begin
                            pos_next   = ins_pos;
                            moves_next = cnt_reg - CNT_W'(ins_pos);
                            src_next   = IDX_W'(cnt_reg - 1'b1);
                            up_next    = 1'b1;
                            state_next = (cnt_reg != CNT_W'(ins_pos)) ? S_SHIFT : S_COMMIT;
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (match_found)
                        begin
                            pos_next   = match_idx;
                            moves_next = cnt_reg - 1'b1 - CNT_W'(match_idx);
                            src_next   = match_idx + 1'b1;
                            up_next    = 1'b0;
                            state_next = (cnt_reg - 1'b1 != CNT_W'(match_idx)) ?
                                         S_SHIFT : S_COMMIT;
                        end
                    end
                    FN_LOOKUP:
                    begin
                        if (match_found)
                        begin
                            status_next = ST_OK;
                            found_next  = match_payload;
                        end
                    end
                    default:
                    begin
                        status_next = ST_REJECT;
                    end
                endcase
            end
            S_SHIFT:
            begin
                // read src this cycle, write it one slot over the next
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (moves_reg != '0)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = src_reg;
                    pend_next  = 1'b1;
                    dst_next   = up_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    src_next   = up_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    moves_next = moves_reg - 1'b1;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                status_next = ST_OK;
                found_next  = '0;
                if (item_reg.func == FN_INSERT)
                begin
                    mem_we            = 1'b1;
                    mem_waddr         = pos_reg;
                    mem_wdata.key     = item_reg.key;
                    mem_wdata.payload = item_reg.payload;
                    cnt_next          = cnt_reg + 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = status_reg;
                    out_next.found_payload = found_reg;
                    out_next.count        = COUNT_W'(cnt_reg);
                    out_next.empty_res    = (cnt_reg == '0);
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            sorted_mode_reg <= 1'b1;
            cmp_vld_reg     <= 1'b0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                sorted_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        rd_ptr_reg  <= rd_ptr_next;
        cmp_idx_reg <= cmp_idx_next;
        pos_reg     <= pos_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        moves_reg   <= moves_next;
        up_reg      <= up_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SKT_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `SKT_ASSERT_IMP(a_we_phase, mem_we, state_reg == S_SHIFT || state_reg == S_COMMIT,
                    "entry store written outside shift or commit")
    `SKT_ASSERT_NXT(a_cnt_hold, state_reg != S_COMMIT, $stable(cnt_reg),
                    "entry count changed outside commit")
    `SKT_ASSERT_NXT(a_start_scan, in_fire, state_reg == S_SEARCH && rd_ptr_reg == '0,
                    "accepted item did not start a scan")
    `SKT_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_reg), "state not one-hot")

endmodule

// File: rtl/core/sktab_mem.sv
// Entry store: one write port, one read port, registered read data.
// Depends on sktab_pkg for the entry type.
`timescale 1ns / 1ps

module sktab_mem #(
    parameter int DEPTH = sktab_pkg::SKT_CAPACITY
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  sktab_pkg::sktab_entry_t     wdata,
    input  logic                        re,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output sktab_pkg::sktab_entry_t     rdata
);
    import sktab_pkg::*;

    sktab_entry_t mem [DEPTH];
    sktab_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/sktab_search.sv
// Shared key compare unit: tracks the first equal entry and the first
// entry whose key is not below the search key over one scan.
// Depends on sktab_pkg.
`timescale 1ns / 1ps

module sktab_search #(
    parameter int DEPTH = sktab_pkg::SKT_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic                              vld,
    input  logic [$clog2(DEPTH)-1:0]          idx,
    input  logic [sktab_pkg::KEY_W-1:0]       key,
    input  sktab_pkg::sktab_entry_t           entry,
    output logic                              match_found,
    output logic [$clog2(DEPTH)-1:0]          match_idx,
    output logic [sktab_pkg::PAYLOAD_W-1:0]   match_payload,
    output logic                              ge_found,
    output logic [$clog2(DEPTH)-1:0]          ge_idx
);
    import sktab_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic                 match_found_reg, match_found_next;
    logic                 ge_found_reg, ge_found_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]     ge_idx_reg, ge_idx_next;
    logic [PAYLOAD_W-1:0] match_payload_reg, match_payload_next;
    logic                 is_eq;
    logic                 is_lt;

    assign is_eq = (entry.key == key);
    assign is_lt = (entry.key < key);

    always_comb
    begin
        match_found_next   = match_found_reg;
        ge_found_next      = ge_found_reg;
        match_idx_next     = match_idx_reg;
        ge_idx_next        = ge_idx_reg;
        match_payload_next = match_payload_reg;
        if (clear)
        begin
            match_found_next = 1'b0;
            ge_found_next    = 1'b0;
        end
        else if (vld)
        begin
            if (!match_found_reg && is_eq)
            begin
                match_found_next   = 1'b1;
                match_idx_next     = idx;
                match_payload_next = entry.payload;
            end
            if (!ge_found_reg && !is_lt)
            begin
                ge_found_next = 1'b1;
                ge_idx_next   = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            ge_found_reg    <= 1'b0;
        end
        else
        begin
            match_found_reg <= match_found_next;
            ge_found_reg    <= ge_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg     <= match_idx_next;
        ge_idx_reg        <= ge_idx_next;
        match_payload_reg <= match_payload_next;
    end

    assign match_found   = match_found_reg;
    assign match_idx     = match_idx_reg;
    assign match_payload = match_payload_reg;
    assign ge_found      = ge_found_reg;
    assign ge_idx        = ge_idx_reg;

endmodule
